// File: hw/rtl/b2bpow_pkg.sv
package b2bpow_pkg;

  typedef logic [63:0] word_t;
  typedef word_t [15:0] vec_t;
  typedef word_t [3:0] msg_t;

  localparam int unsigned NumRounds = 12;
  localparam int unsigned MsgBytes  = 40;
  localparam int unsigned DigBytes  = 8;

  localparam word_t Iv0 = 64'h6a09e667f3bcc908;
  localparam word_t Iv1 = 64'hbb67ae8584caa73b;
  localparam word_t Iv2 = 64'h3c6ef372fe94f82b;
  localparam word_t Iv3 = 64'ha54ff53a5f1d36f1;
  localparam word_t Iv4 = 64'h510e527fade682d1;
  localparam word_t Iv5 = 64'h9b05688c2b3e6c1f;
  localparam word_t Iv6 = 64'h1f83d9abfb41bd6b;
  localparam word_t Iv7 = 64'h5be0cd19137e2179;

  localparam word_t H0 = Iv0 ^ 64'h0000_0000_0101_0000 ^ 64'(DigBytes);

  // register indexes
  localparam logic [2:0] RegHash0  = 3'd0;
  localparam logic [2:0] RegHash1  = 3'd1;
  localparam logic [2:0] RegHash2  = 3'd2;
  localparam logic [2:0] RegHash3  = 3'd3;
  localparam logic [2:0] RegThresh = 3'd4;

  // message word schedule, row per round, nibble i is s[i]
  function automatic logic [3:0] sigma(input int unsigned r, input int unsigned i);
    logic [63:0] row;
    unique case (r % 10)
      0: row = 64'hfedcba9876543210;
      1: row = 64'h357b20c16df984ae;
      2: row = 64'h491763eadf250c8b;
      3: row = 64'h8f04a562ebcd1397;
      4: row = 64'hd386cb1efa427509;
      5: row = 64'h91ef57d438b0a6c2;
      6: row = 64'hb8293670a4def15c;
      7: row = 64'ha2684f05931ce7bd;
      8: row = 64'h5a417d2c803b9ef6;
      default: row = 64'h0dc3e9bf5167482a;
    endcase
    return row[i*4 +: 4];
  endfunction

  function automatic word_t msg_word(input msg_t m, input word_t n, input logic [3:0] k);
    word_t w;
    unique case (k)
      4'd0: w = n;
      4'd1: w = m[0];
      4'd2: w = m[1];
      4'd3: w = m[2];
      4'd4: w = m[3];
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned s);
    return (x >> s) | (x << (64 - s));
  endfunction

endpackage

// File: hw/rtl/blake2b_work_nonce_checker.sv
// channel  | direction | beat payload
// nonce    | in        | candidate_nonce_i
// result   | out       | tested_nonce_o, digest_value_o, meets_threshold_o
// config   | apb       | regs 0..4 at 8*i, 64 bit data
//
// 24 half-round stages, then the output register
// one beat accepted per cycle unless stalled; the whole chain advances together
// a stall at the output freezes every stage unless the output is empty
// reset clears the valid bits and the config registers to zero
module blake2b_work_nonce_checker import b2bpow_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        nonce_valid_i,
  output logic        nonce_stall_o,
  input  logic [63:0] candidate_nonce_i,
  output logic        result_valid_o,
  input  logic        result_stall_i,
  output logic [63:0] tested_nonce_o,
  output logic [63:0] digest_value_o,
  output logic        meets_threshold_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned Stages = 2 * NumRounds;

  msg_t  hash_q;
  word_t thresh_q;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q   <= '0;
      thresh_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        RegHash0:  hash_q[0] <= pwdata;
        RegHash1:  hash_q[1] <= pwdata;
        RegHash2:  hash_q[2] <= pwdata;
        RegHash3:  hash_q[3] <= pwdata;
        RegThresh: thresh_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegHash0:  prdata = hash_q[0];
      RegHash1:  prdata = hash_q[1];
      RegHash2:  prdata = hash_q[2];
      RegHash3:  prdata = hash_q[3];
      RegThresh: prdata = thresh_q;
      default:   prdata = '0;
    endcase
  end

  logic en;
  logic out_valid_q;
  word_t out_nonce_q, out_dig_q;
  logic out_meet_q;

  assign en            = !out_valid_q || !result_stall_i;
  assign nonce_stall_o = !en;

  vec_t v_init;
  always_comb begin
    v_init     = {Iv7, Iv6, Iv5, Iv4, Iv3, Iv2, Iv1, Iv0,
                  Iv7, Iv6, Iv5, Iv4, Iv3, Iv2, Iv1, H0};
    v_init[12] = Iv4 ^ 64'(MsgBytes);
    v_init[14] = ~Iv6;
  end

  vec_t  v_s [Stages+1];
  word_t n_s [Stages+1];
  logic  vl_s [Stages+1];

  assign v_s[0]  = v_init;
  assign n_s[0]  = candidate_nonce_i;
  assign vl_s[0] = nonce_valid_i;

  for (genvar k = 0; k < Stages; k++) begin : g_half
    b2bpow_half #(.Round(k / 2), .Diag(k % 2 == 1)) u_half (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(vl_s[k]), .v_i(v_s[k]), .nonce_i(n_s[k]), .hash_i(hash_q),
      .valid_o(vl_s[k+1]), .v_o(v_s[k+1]), .nonce_o(n_s[k+1])
    );
  end

  word_t dig;
  assign dig = H0 ^ v_s[Stages][0] ^ v_s[Stages][8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vl_s[Stages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_nonce_q <= n_s[Stages];
      out_dig_q   <= dig;
      out_meet_q  <= dig >= thresh_q;
    end
  end

  assign result_valid_o    = out_valid_q;
  assign tested_nonce_o    = out_nonce_q;
  assign digest_value_o    = out_dig_q;
  assign meets_threshold_o = out_meet_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nonce_stall_o |-> result_valid_o && result_stall_i) else $error("bad stall");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_stall_i |=> $stable(digest_value_o) && result_valid_o)
    else $error("result changed under stall");
  a_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && thresh_q == '0 |-> meets_threshold_o) else $error("zero threshold");

endmodule

// File: hw/rtl/b2bpow_half.sv
// one half round (four column or four diagonal mixes), registered
module b2bpow_half import b2bpow_pkg::*; #(
  parameter int unsigned Round = 0,
  parameter bit          Diag  = 1'b0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  vec_t  v_i,
  input  word_t nonce_i,
  input  msg_t  hash_i,
  output logic  valid_o,
  output vec_t  v_o,
  output word_t nonce_o
);

  vec_t v_d, v_q;
  word_t nonce_q;
  logic valid_q;

  always_comb begin
    logic [3:0] a, b, c, d;
    int unsigned j;
    word_t x, y;
    v_d = v_i;
    for (int g = 0; g < 4; g++) begin
      a = 4'(g);
      b = Diag ? 4'(4 + ((g + 1) % 4)) : 4'(4 + g);
      c = Diag ? 4'(8 + ((g + 2) % 4)) : 4'(8 + g);
      d = Diag ? 4'(12 + ((g + 3) % 4)) : 4'(12 + g);
      j = (Diag ? 8 : 0) + 2 * g;
      x = msg_word(hash_i, nonce_i, sigma(Round, j));
      y = msg_word(hash_i, nonce_i, sigma(Round, j + 1));
      v_d[a] = v_d[a] + v_d[b] + x;
      v_d[d] = rotr(v_d[d] ^ v_d[a], 32);
      v_d[c] = v_d[c] + v_d[d];
      v_d[b] = rotr(v_d[b] ^ v_d[c], 24);
      v_d[a] = v_d[a] + v_d[b] + y;
      v_d[d] = rotr(v_d[d] ^ v_d[a], 16);
      v_d[c] = v_d[c] + v_d[d];
      v_d[b] = rotr(v_d[b] ^ v_d[c], 63);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q     <= v_d;
      nonce_q <= nonce_i;
    end
  end

  assign valid_o = valid_q;
  assign v_o     = v_q;
  assign nonce_o = nonce_q;

endmodule
